// ===== design/int_to_decimal_ascii_macros.svh =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_macros : assertion helpers
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication
`define I2DA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2DA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/i2da_pkg.sv =====
// ----------------------------------------------------------------------------
// i2da_pkg
// Types and constants shared by the decimal text converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

  localparam int VALUE_W    = 32;
  localparam int MINLEN_W   = 4;
  localparam int MAX_LENGTH = 15;
  localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
  localparam int SUM_W      = LEN_W + 1;
  localparam int DIGIT_CAP  = 10;
  localparam int BCD_W      = 4 * DIGIT_CAP;
  localparam int DIG_W      = 4;
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int IN_TDATA_W = 40;
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [LEN_W-1:0]   want;
  } i2da_job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CONV,
    B_SIZE,
    B_EMIT
  } i2da_state_t;

endpackage

// ===== design/i2da_front.sv =====
// ----------------------------------------------------------------------------
// i2da_front
// Accepts input words, splits sign and magnitude, clamps the minimum length.
// ----------------------------------------------------------------------------
module i2da_front import i2da_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [31:0] value, [35:32] min_length
  output logic                  job_valid,
  input  logic                  job_ready,
  output i2da_job_t             job
);

  logic                  vld_r;
  i2da_job_t             job_r;
  i2da_job_t             job_nxt;
  logic [VALUE_W-1:0]    value;
  logic [MINLEN_W-1:0]   min_length;

  assign value      = in_tdata[VALUE_W-1:0];
  assign min_length = in_tdata[VALUE_W +: MINLEN_W];

  assign in_tready = !vld_r || job_ready;
  assign job_valid = vld_r;
  assign job       = job_r;

  always_comb begin
    job_nxt.neg = value[VALUE_W-1];
    job_nxt.mag = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
    if (32'(min_length) > MAX_LENGTH) begin
      job_nxt.want = LEN_W'(MAX_LENGTH);
    end else begin
      job_nxt.want = LEN_W'(min_length);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      job_r <= job_nxt;
    end
  end

endmodule

// ===== design/i2da_fifo.sv =====
// ----------------------------------------------------------------------------
// i2da_fifo
// Short job queue between front and back.
// ----------------------------------------------------------------------------
`include "int_to_decimal_ascii_macros.svh"

module i2da_fifo import i2da_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  i2da_job_t wr_job,
  output logic      rd_valid,
  input  logic      rd_ready,
  output i2da_job_t rd_job
);

  i2da_job_t         mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FCNT_W-1:0] count_r;
  logic              push;
  logic              pop;

  assign wr_ready = (count_r != FCNT_W'(FIFO_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == FIFO_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == FIFO_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + FCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - FCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  `I2DA_ASSERT_NOW(a_fifo_bound, 1'b1, 32'(count_r) <= FIFO_DEPTH, "queue overfilled")

endmodule

// ===== design/i2da_back.sv =====
// ----------------------------------------------------------------------------
// i2da_back
// Bit-serial double dabble, digit count, then one character word per cycle while out_tready allows.
// ----------------------------------------------------------------------------
`include "int_to_decimal_ascii_macros.svh"

module i2da_back import i2da_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  i2da_job_t job,
  output logic      out_tvalid,
  input  logic      out_tready,
  output logic [7:0] out_tdata,   // [7:0] char_code
  output logic      out_tlast     // last_char
);

  i2da_state_t        state_r, state_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [VALUE_W-1:0] shreg_r, shreg_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic [LEN_W-1:0]   want_r, want_nxt;
  logic [LEN_W-1:0]   pad_r, pad_nxt;
  logic [DIG_W-1:0]   dig_r, dig_nxt;
  logic               ov_r, ov_nxt;
  logic [7:0]         oc_r, oc_nxt;
  logic               ol_r, ol_nxt;
  logic [BCD_W-1:0]   adj;
  logic [DIG_W-1:0]   ndig;
  logic [SUM_W-1:0]   total;
  logic               slot;
  logic [3:0]         digit;

  assign out_tvalid = ov_r;
  assign out_tdata  = oc_r;
  assign out_tlast  = ol_r;
  assign slot       = !ov_r || out_tready;
  assign job_ready  = (state_r == B_IDLE);
  assign digit      = bcd_r[{dig_r, 2'b00} +: 4];

  always_comb begin
    for (int k = 0; k < DIGIT_CAP; k++) begin
      adj[4*k +: 4] = (bcd_r[4*k +: 4] >= 4'd5) ? bcd_r[4*k +: 4] + 4'd3 : bcd_r[4*k +: 4];
    end
  end

  always_comb begin
    ndig = DIG_W'(1);
    for (int k = 1; k < DIGIT_CAP; k++) begin
      if (bcd_r[4*k +: 4] != 4'd0) begin
        ndig = DIG_W'(k + 1);
      end
    end
    total = SUM_W'(ndig) + SUM_W'(neg_r);
  end

  always_comb begin
    state_nxt = state_r;
    bcd_nxt   = bcd_r;
    shreg_nxt = shreg_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    want_nxt  = want_r;
    pad_nxt   = pad_r;
    dig_nxt   = dig_r;
    ov_nxt    = ov_r && !out_tready;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          bcd_nxt   = '0;
          shreg_nxt = job.mag;
          cnt_nxt   = '0;
          neg_nxt   = job.neg;
          want_nxt  = job.want;
          state_nxt = B_CONV;
        end
      end
      B_CONV: begin
        bcd_nxt   = {adj[BCD_W-2:0], shreg_r[VALUE_W-1]};
        shreg_nxt = {shreg_r[VALUE_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(VALUE_W - 1)) begin
          state_nxt = B_SIZE;
        end
      end
      B_SIZE: begin
        dig_nxt = ndig - DIG_W'(1);
        if (SUM_W'(want_r) > total) begin
          pad_nxt = LEN_W'(SUM_W'(want_r) - total);
        end else begin
          pad_nxt = '0;
        end
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (slot) begin
          ov_nxt = 1'b1;
          ol_nxt = 1'b0;
          if (neg_r) begin
            oc_nxt  = CH_MINUS;
            neg_nxt = 1'b0;
          end else if (pad_r != '0) begin
            oc_nxt  = CH_ZERO;
            pad_nxt = pad_r - LEN_W'(1);
          end else begin
            oc_nxt  = CH_ZERO + 8'(digit);
            dig_nxt = dig_r - DIG_W'(1);
            if (dig_r == '0) begin
              ol_nxt    = 1'b1;
              state_nxt = B_IDLE;
            end
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcd_r   <= bcd_nxt;
    shreg_r <= shreg_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    want_r  <= want_nxt;
    pad_r   <= pad_nxt;
    dig_r   <= dig_nxt;
    oc_r    <= oc_nxt;
    ol_r    <= ol_nxt;
  end

  `I2DA_ASSERT_NEXT(a_conv_done, state_r == B_CONV && cnt_r == CNT_W'(VALUE_W - 1), state_r == B_SIZE, "conversion length wrong")
  `I2DA_ASSERT_NOW(a_char_set, ov_r, oc_r == CH_MINUS || (oc_r >= CH_ZERO && oc_r <= CH_NINE), "bad character")
  `I2DA_ASSERT_NOW(a_dig_range, state_r == B_EMIT, 32'(dig_r) < DIGIT_CAP, "digit index out of range")

endmodule

// ===== design/int_to_decimal_ascii.sv =====
// From the accepting edge of an input word, the first character passes the
// queue write, job load, 32-step double-dabble shift, digit-count state and
// output register, then one character per cycle while out_tready allows.
// The bit-serial converter in the back part takes one number at a time; the
// queue holds further jobs meanwhile. Reset: synchronous, active-low rst_n
// clears queue, FSM and output valid.
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed 32-bit integer to zero-padded decimal ASCII text, one char per word.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii import i2da_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [31:0] value, [35:32] min_length
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] char_code
  output logic                  out_tlast   // last_char
);

  i2da_job_t fr_job;
  i2da_job_t bk_job;
  logic      fr_valid;
  logic      fr_ready;
  logic      bk_valid;
  logic      bk_ready;

  i2da_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  i2da_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_job   (fr_job),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_job   (bk_job)
  );

  i2da_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (bk_valid),
    .job_ready  (bk_ready),
    .job        (bk_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
